FILE: design/mpu_pkg.sv
// shared types and constants for the midi uart port with ack queue
// no dependencies; imported by mpu_core and the top level
package mpu_pkg;

  localparam int REPLY_DEPTH_DEF = 16;

  localparam logic [7:0] STATUS_IDLE    = 8'h3F;
  localparam logic [7:0] STATUS_NO_DATA = 8'h80;
  localparam logic [7:0] CMD_RESET      = 8'hFF;
  localparam logic [7:0] CMD_UART       = 8'h3F;
  localparam logic [7:0] ACK_BYTE       = 8'hFE;
  localparam logic [7:0] EMPTY_READ     = 8'hFF;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;
  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  typedef struct packed {
    logic       command;
    logic       port_select;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       midi_valid;
    logic [7:0] midi_byte;
    logic       synth_reset;
    logic       irq_level;
  } rsp_t;

endpackage

FILE: design/mpu_ifs.sv
// valid/ready channel interfaces: bus request, result and config write
// standalone, no package dependency
interface mpu_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       port_select;
  logic [7:0] write_data;
  modport source (output valid, command, port_select, write_data, input ready);
  modport sink   (input valid, command, port_select, write_data, output ready);
endinterface

interface mpu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       midi_valid;
  logic [7:0] midi_byte;
  logic       synth_reset;
  logic       irq_level;
  modport source (output valid, read_data, midi_valid, midi_byte, synth_reset, irq_level,
                  input ready);
  modport sink   (input valid, read_data, midi_valid, midi_byte, synth_reset, irq_level,
                  output ready);
endinterface

interface mpu_cfg_if;
  logic valid;
  logic ready;
  logic irq_enabled;
  modport source (output valid, irq_enabled, input ready);
  modport sink   (input valid, irq_enabled, output ready);
endinterface

FILE: design/mpu_core.sv
// command decode, uart mode flag and reply queue occupancy
// depends on mpu_pkg
module mpu_core import mpu_pkg::*; #(
  parameter int REPLY_DEPTH = REPLY_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  input  logic irq_enabled,
  output rsp_t rsp
);

  localparam int CW = $clog2(REPLY_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(REPLY_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  // the queue only ever holds ack bytes, so occupancy alone is its content
  logic [CW-1:0] count_r, count_nxt;
  logic          uart_mode_r, uart_mode_nxt;
  logic          empty, full;

  assign empty = (count_r == '0);
  assign full  = (count_r == FULL_CNT);

  always_comb begin
    count_nxt     = count_r;
    uart_mode_nxt = uart_mode_r;
    rsp           = '0;
    if (req.command == ACC_READ) begin
      if (req.port_select == PORT_CTRL) begin
        rsp.read_data = STATUS_IDLE | (empty ? STATUS_NO_DATA : 8'h00);
      end else if (empty) begin
        rsp.read_data = EMPTY_READ;
      end else begin
        rsp.read_data = ACK_BYTE;
        count_nxt     = count_r - ONE_CNT;
      end
    end else if (req.port_select == PORT_CTRL) begin
      if (req.write_data == CMD_RESET) begin
        // flush then queue the ack
        uart_mode_nxt   = 1'b0;
        count_nxt       = ONE_CNT;
        rsp.synth_reset = 1'b1;
      end else if (req.write_data == CMD_UART) begin
        uart_mode_nxt = 1'b1;
        if (!full) count_nxt = count_r + ONE_CNT;
      end else if (!uart_mode_r && !full) begin
        count_nxt = count_r + ONE_CNT;
      end
    end else begin
      rsp.midi_valid = 1'b1;
      rsp.midi_byte  = req.write_data;
    end
    rsp.irq_level = irq_enabled && (count_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      uart_mode_r <= 1'b0;
    end else if (fire) begin
      count_r     <= count_nxt;
      uart_mode_r <= uart_mode_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("reply queue count above depth");

  a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.command == ACC_WRITE && req.port_select == PORT_CTRL &&
    req.write_data == CMD_RESET |=> count_r == ONE_CNT && !uart_mode_r)
    else $error("reset command did not leave exactly one ack");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.command == ACC_READ && empty |=> $stable(count_r))
    else $error("read of empty queue changed occupancy");

  a_midi_excl: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rsp.midi_valid |-> rsp.read_data == 8'h00 && !rsp.synth_reset)
    else $error("midi byte emitted alongside read or synth reset");

endmodule

FILE: design/midi_uart_port_with_ack_queue.sv
// top level: request register, mpu_core decode, result register, config reg
// depends on mpu_pkg, mpu_ifs (interfaces) and mpu_core
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, port_select, write_data
//   out_ch   out  valid/ready    read_data, midi_valid, midi_byte, synth_reset, irq_level
//   cfg_ch   in   valid/ready    irq_enabled (always ready)
//
// one request per cycle while out_ch.ready is high; each passes the request register, then the result register.
// state updates as a request moves from the request register to the result register.
// a stalled result register holds; the request register still takes a request
// in the cycle the result is taken (in_ch.ready follows out_ch.ready).
// synchronous active-low reset: empty queue, intelligent mode, irq enabled.
module midi_uart_port_with_ack_queue import mpu_pkg::*; #(
  parameter int REPLY_DEPTH = REPLY_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mpu_req_if.sink   in_ch,
  mpu_rsp_if.source out_ch,
  mpu_cfg_if.sink   cfg_ch
);

  logic s1_v_r, s1_v_nxt;
  req_t s1_req_r;
  logic out_v_r, out_v_nxt;
  rsp_t out_rsp_r, core_rsp;
  logic irq_en_r;
  logic adv, in_fire;

  assign adv     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign s1_v_nxt  = in_fire || (s1_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && !out_ch.ready);

  mpu_core #(.REPLY_DEPTH(REPLY_DEPTH)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (adv),
    .req         (s1_req_r),
    .irq_enabled (irq_en_r),
    .rsp         (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      irq_en_r <= 1'b1;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_ch.valid) irq_en_r <= cfg_ch.irq_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.command     <= in_ch.command;
      s1_req_r.port_select <= in_ch.port_select;
      s1_req_r.write_data  <= in_ch.write_data;
    end
    if (adv) out_rsp_r <= core_rsp;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.read_data   = out_rsp_r.read_data;
  assign out_ch.midi_valid  = out_rsp_r.midi_valid;
  assign out_ch.midi_byte   = out_rsp_r.midi_byte;
  assign out_ch.synth_reset = out_rsp_r.synth_reset;
  assign out_ch.irq_level   = out_rsp_r.irq_level;

endmodule
